/* rtl/swmq_pkg.sv */
// Shared types and codes for the stack with running median.
package swmq_pkg;

  // Command codes carried on the action port.
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } swmq_status_e;

  // What every cell of the sorted chain does in a cycle. The shifted forms
  // also move the whole window one cell so that the median stays in place.
  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_INS,
    MODE_INS_SH,
    MODE_DEL,
    MODE_DEL_SH
  } swmq_mode_e;

  // Compare flags that a cell shows its neighbours.
  typedef struct packed {
    logic occ;
    logic gt;
    logic ge;
  } swmq_flags_t;

endpackage

/* rtl/swmq_ram.sv */
// Generic single-write, single-read memory with a registered read port.
module swmq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/swmq_cell.sv */
// One cell of the sorted chain: holds one value and moves it to or from its neighbours.
module swmq_cell import swmq_pkg::*; #(
  parameter int unsigned VW       = 16,
  parameter int unsigned IW       = 11,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic        clk_i,
  input  swmq_mode_e  mode_i,
  input  logic [VW-1:0] key_i,
  input  logic [IW-1:0] lo_i,
  input  logic [IW-1:0] hi_i,
  input  logic [VW-1:0] left_val_i,
  input  swmq_flags_t   left_flg_i,
  input  logic [VW-1:0] right_val_i,
  input  swmq_flags_t   right_flg_i,
  output logic [VW-1:0] val_o,
  output swmq_flags_t   flg_o
);

  localparam logic [IW-1:0] Idx = IW'(CELL_IDX);

  logic [VW-1:0] val_q, val_d;
  swmq_flags_t   flg;

  // A cell is occupied when its index lies inside the live window.
  always_comb begin
    flg.occ = (Idx >= lo_i) && (Idx < hi_i);
    flg.gt  = flg.occ && (val_q > key_i);
    flg.ge  = flg.occ && (val_q >= key_i);
  end

  always_comb begin
    val_d = val_q;
    unique case (mode_i)
      MODE_INS: begin
        if (left_flg_i.gt) begin
          val_d = left_val_i;
        end else if (!flg.occ || flg.gt) begin
          val_d = key_i;
        end
      end
      MODE_INS_SH: begin
        if (flg.gt) begin
          val_d = val_q;
        end else if (!right_flg_i.occ || right_flg_i.gt) begin
          val_d = key_i;
        end else begin
          val_d = right_val_i;
        end
      end
      MODE_DEL: begin
        if (flg.ge) begin
          val_d = right_val_i;
        end
      end
      MODE_DEL_SH: begin
        if (!left_flg_i.ge) begin
          val_d = left_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign flg_o = flg;

endmodule

/* rtl/stack_with_median_query.sv */
// Top level: bounded stack with a running median kept in a chain of sorting cells.
// The accepting edge moves the control into its execute state, and done_o is registered from that
// state; the result is transferred while done_o is high.
// A command is accepted only in the idle state; busy is high for the one execute cycle, which a pop
// needs because the top of stack comes out of the registered read port of the stack memory.
// Reset clears the entry count and the control state; stored values are undefined until written
// and there is no clearing pass. Results cannot be stalled: each is shown for exactly one cycle.
module stack_with_median_query import swmq_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] value_i,
  output logic        done_o,
  output logic [15:0] result_value_o,
  output logic [1:0]  status_o
);

  // The sorted values sit in a window of the cell row. The window slides by one cell whenever
  // the median index moves, so the median itself always lives in cell MedPos and is read there
  // without any selection logic.
  localparam int unsigned MedPos = (STACK_DEPTH + 1) / 2 - 1;
  localparam int unsigned NCells = MedPos + STACK_DEPTH / 2 + 1;
  localparam int unsigned IW     = $clog2(NCells + 1);
  localparam int unsigned AW     = $clog2(STACK_DEPTH);
  localparam int unsigned CW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW     = VALUE_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic          state_q, state_d;
  logic [1:0]    action_q;
  logic [VW-1:0] value_q;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] hi_q, hi_d;
  logic          done_q, done_d;
  logic [15:0]   result_q, result_d;
  swmq_status_e  status_q, status_d;

  logic          accept;
  logic          full, empty;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_rdata;
  swmq_mode_e    mode;
  logic [VW-1:0] key;

  logic [VW-1:0] cell_val [NCells];
  swmq_flags_t   cell_flg [NCells];

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_EXEC);
  assign full   = (count_q == CW'(STACK_DEPTH));
  assign empty  = (count_q == '0);

  // The stack memory read for a pop is launched at the accepting edge so that the top value is
  // ready in the execute cycle. A push writes in the execute cycle.
  assign ram_re    = accept;
  assign ram_raddr = AW'(count_q - CW'(1));
  assign ram_waddr = AW'(count_q);
  assign ram_we    = (state_q == ST_EXEC) && (action_q == ACT_PUSH) && !full;

  swmq_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Execute cycle. A push moves the window down one cell when the count was even, because the
  // median index then advances; a pop moves it up one cell when the count was odd.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    done_d   = 1'b0;
    result_d = result_q;
    status_d = status_q;
    mode     = MODE_HOLD;
    key      = (action_q == ACT_POP) ? ram_rdata : value_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d  = ST_IDLE;
        done_d   = 1'b1;
        result_d = '0;
        status_d = ST_OK;
        unique case (action_q)
          ACT_PUSH: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              count_d = count_q + CW'(1);
              if (count_q[0]) begin
                mode = MODE_INS;
                hi_d = hi_q + IW'(1);
              end else begin
                mode = MODE_INS_SH;
                lo_d = lo_q - IW'(1);
              end
            end
          end
          ACT_POP: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              result_d = 16'(ram_rdata);
              count_d  = count_q - CW'(1);
              if (count_q[0]) begin
                mode = MODE_DEL_SH;
                lo_d = lo_q + IW'(1);
              end else begin
                mode = MODE_DEL;
                hi_d = hi_q - IW'(1);
              end
            end
          end
          ACT_PEEK: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              result_d = 16'(cell_val[MedPos]);
            end
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      lo_q    <= IW'(MedPos + 1);
      hi_q    <= IW'(MedPos + 1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      done_q  <= done_d;
    end
  end

  // Command and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      value_q  <= VW'(value_i);
    end
    result_q <= result_d;
    status_q <= status_d;
  end

  // The row of sorting cells; the cells at each end see an empty neighbour.
  for (genvar j = 0; j < NCells; j++) begin : g_cell
    logic [VW-1:0] lval, rval;
    swmq_flags_t   lflg, rflg;

    if (j == 0) begin : g_left_edge
      assign lval = '0;
      assign lflg = '0;
    end else begin : g_left
      assign lval = cell_val[j-1];
      assign lflg = cell_flg[j-1];
    end

    if (j == NCells - 1) begin : g_right_edge
      assign rval = '0;
      assign rflg = '0;
    end else begin : g_right
      assign rval = cell_val[j+1];
      assign rflg = cell_flg[j+1];
    end

    swmq_cell #(
      .VW       (VW),
      .IW       (IW),
      .CELL_IDX (j)
    ) u_cell (
      .clk_i       (clk_i),
      .mode_i      (mode),
      .key_i       (key),
      .lo_i        (lo_q),
      .hi_i        (hi_q),
      .left_val_i  (lval),
      .left_flg_i  (lflg),
      .right_val_i (rval),
      .right_flg_i (rflg),
      .val_o       (cell_val[j]),
      .flg_o       (cell_flg[j])
    );
  end

  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;

  // A result only ever follows an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

  // The live window of the cell row always spans exactly the stored entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (hi_q - lo_q) == IW'(count_q))
    else $error("sorted window out of step with the entry count");

  // The entry count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(STACK_DEPTH))
    else $error("entry count beyond capacity");

  // A transfer that is not ok carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && (status_o != ST_OK)) |-> (result_value_o == '0))
    else $error("non-zero value with an error status");

endmodule

/* sim/stack_with_median_query_tb.sv */
// Self-checking testbench for the bounded stack with running median query.
module stack_with_median_query_tb;
  import swmq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block is built at its default size. The testbench keeps its own copy
  // of the depth so that it can fill the stack and provoke a dropped push.
  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned VALUE_BITS = 16;

  // The fourth action code has no name in the package. The block must treat
  // it as a no-op that still returns a result with status ok.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Generous ceiling on run length. A correct run is roughly seventeen
  // hundred transfers.
  localparam int CYCLE_LIMIT = 400000;

  // One expected result: the value and the status of a single transfer.
  typedef struct {
    logic [15:0]  value;
    swmq_status_e status;
  } cmd_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  action_i       = ACT_PUSH;
  logic [15:0] value_i        = '0;
  logic        done_o;
  logic [15:0] result_value_o;
  logic [1:0]  status_o;

  // Shadow state of the block: the stack in push order, and the same values
  // kept in ascending order so that the median can be read off directly.
  logic [15:0] shadow_stack[$];
  logic [15:0] shadow_sorted[$];

  // Results still owed by the block, oldest first.
  cmd_result_t pending_results[$];
  cmd_result_t oldest_result;

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Percentage of cycles in which the sender stays idle.
  int gap_percent = 0;

  stack_with_median_query #(
    .STACK_DEPTH(DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .status_o      (status_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Any hang in the handshake ends the run here rather than running forever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stack_with_median_query verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Applies one command to the shadow state and returns the result that the
  // block ought to give for it. Pop removes one copy of the popped value from
  // the sorted list, which matters when the stack holds duplicates. The
  // median is the lower one when the count is even.
  function automatic cmd_result_t predict_command(input logic [1:0] act,
                                                  input logic [15:0] val);
    cmd_result_t res;
    int          n;
    int          pos;
    logic [15:0] top;
    res.value  = '0;
    res.status = ST_OK;
    n          = shadow_stack.size();
    case (act)
      ACT_PUSH: begin
        if (n >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_stack.push_back(val);
          pos = 0;
          while (pos < n && shadow_sorted[pos] <= val) pos++;
          shadow_sorted.insert(pos, val);
        end
      end
      ACT_POP: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          top       = shadow_stack.pop_back();
          res.value = top;
          pos       = 0;
          while (shadow_sorted[pos] != top) pos++;
          shadow_sorted.delete(pos);
        end
      end
      ACT_PEEK: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = shadow_sorted[(n + 1) / 2 - 1];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offers one command until a transfer takes place, that is until a rising
  // edge sees start high and busy low. In every cycle the sender stays idle
  // with a chance of gap_percent, holding start low for that cycle. The
  // expectation is queued at the edge of the transfer.
  task automatic send_command(input logic [1:0] act, input logic [15:0] val);
    logic taken;
    taken = 1'b0;
    while (!taken) begin
      if ($urandom_range(0, 99) < gap_percent) begin
        start <= 1'b0;
      end else begin
        start    <= 1'b1;
        action_i <= act;
        value_i  <= val;
      end
      @(posedge clk_i);
      taken = start && !busy;
    end
    pending_results.push_back(predict_command(act, val));
  endtask

  // Values are drawn from a tiny range often enough to build up duplicates,
  // which exercise the removal of one copy from the sorted list, and the
  // extremes turn up regularly as well.
  function automatic logic [15:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return 16'($urandom_range(0, 7));
    if (pick == 3) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Results cannot be held off, so each one is checked at the edge that ends
  // its single cycle on the ports, against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result: value %h status %0d",
                                  result_value_o, status_o));
      end else begin
        oldest_result = pending_results.pop_front();
        if (result_value_o !== oldest_result.value) begin
          report_mismatch($sformatf("result_value %h, predicted %h",
                                    result_value_o, oldest_result.value));
        end
        if (status_o !== oldest_result.status) begin
          report_mismatch($sformatf("status %0d, predicted %s",
                                    status_o, oldest_result.status.name()));
        end
      end
    end
  end

  // Pop, peek and the unused code on an empty stack.
  task automatic test_empty_stack();
    gap_percent = 0;
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_PEEK, 16'hFFFF);
    send_command(ACT_UNUSED, 16'hFFFF);
    send_command(ACT_POP, 16'hFFFF);
  endtask

  // Extreme values, duplicates and the lower median of an even count. Every
  // bit of the value field is toggled by the alternating patterns.
  task automatic test_extremes();
    gap_percent = 50;
    send_command(ACT_PUSH, 16'h0000);
    send_command(ACT_PUSH, 16'hFFFF);
    send_command(ACT_PEEK, 16'h1234);
    send_command(ACT_PUSH, 16'h8000);
    send_command(ACT_PEEK, 16'h0000);
    send_command(ACT_PUSH, 16'hFFFF);
    send_command(ACT_PEEK, 16'h0000);
    send_command(ACT_UNUSED, 16'h5555);
    send_command(ACT_POP, 16'hAAAA);
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_PEEK, 16'h0000);
    send_command(ACT_PUSH, 16'h5555);
    send_command(ACT_PUSH, 16'hAAAA);
    send_command(ACT_PUSH, 16'h5555);
    send_command(ACT_PEEK, 16'h0000);
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_PEEK, 16'h0000);
  endtask

  // Fills the stack to the brim with occasional median queries, offers
  // pushes that must be dropped, then pops part of it off again.
  task automatic test_full_stack();
    int k;
    gap_percent = 20;
    k = 0;
    while (shadow_stack.size() < DEPTH) begin
      send_command(ACT_PUSH, random_value());
      k++;
      if (k % 97 == 0) send_command(ACT_PEEK, random_value());
    end
    send_command(ACT_PUSH, 16'hFFFF);
    send_command(ACT_PEEK, 16'h0000);
    send_command(ACT_PUSH, 16'h0000);
    send_command(ACT_POP, 16'h0000);
    send_command(ACT_PUSH, 16'h7FFF);
    send_command(ACT_PUSH, 16'h8001);
    k = 0;
    while (k < 64 && shadow_stack.size() > 0) begin
      send_command(ACT_POP, random_value());
      k++;
      if (k % 16 == 0) send_command(ACT_PEEK, random_value());
    end
    send_command(ACT_POP, 16'h0000);
  endtask

  // Random command stream with a slight upward drift in stack depth, so that
  // both the empty cases and deep stacks with many duplicates occur.
  task automatic test_random_mix(input int idle_percent, input int count);
    int unsigned pick;
    logic [1:0]  act;
    gap_percent = idle_percent;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      act = ACT_PUSH;
      else if (pick < 70) act = ACT_POP;
      else if (pick < 95) act = ACT_PEEK;
      else                act = ACT_UNUSED;
      send_command(act, random_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_extremes();
    test_random_mix(28, 200);
    test_random_mix(71, 200);
    test_random_mix(0, 200);
    test_full_stack();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Keep clocking after the last expected result so that a stray extra result would be seen.
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("stack_with_median_query verification clean");
    end else begin
      $display("stack_with_median_query verification failed");
    end
    $finish;
  end

endmodule
